// ===== hdl/nfe_pkg.sv =====
`timescale 1ns / 1ps
package nfe_pkg;

  // Field widths of the channels and of the configuration registers.
  localparam int FUNC_W         = 3;
  localparam int PAGE_W         = 10;
  localparam int COL_W          = 10;
  localparam int BYTE_W         = 8;
  localparam int PAGE_BYTES_W   = 11;
  localparam int SPARE_BYTES_W  = 6;
  localparam int SPARE_AVAIL_W  = 6;
  localparam int PPB_W          = 7;
  localparam int CHIP_PAGES_W   = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 11;

  // Default geometry of the backing store.
  localparam int DEF_MAX_PAGE_BYTES  = 1024;
  localparam int DEF_MAX_SPARE_BYTES = 32;
  localparam int DEF_MAX_PAGES       = 1024;

  // Register values after reset.
  localparam logic [PAGE_BYTES_W-1:0]  RST_PAGE_BYTES  = 11'd1024;
  localparam logic [SPARE_BYTES_W-1:0] RST_SPARE_BYTES = 6'd32;
  localparam logic [SPARE_AVAIL_W-1:0] RST_SPARE_AVAIL = 6'd8;
  localparam logic [PPB_W-1:0]         RST_PPB         = 7'd32;
  localparam logic [CHIP_PAGES_W-1:0]  RST_CHIP_PAGES  = 11'd1024;

  // Spare offsets from this one on are erased in the initial image.
  localparam int INIT_SPARE_AVAIL = 8;

  localparam logic [BYTE_W-1:0] BYTE_ERASED = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_FILL   = 8'hCC;
  localparam logic [BYTE_W-1:0] BYTE_ZERO   = 8'h00;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ_MAIN  = 3'd0,
    FN_READ_SPARE = 3'd1,
    FN_PROG_MAIN  = 3'd2,
    FN_PROG_SPARE = 3'd3,
    FN_ERASE      = 3'd4,
    FN_MARK_BAD   = 3'd5,
    FN_CHECK_BAD  = 3'd6
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_BYTES  = 3'd0,
    CFG_SPARE_BYTES = 3'd1,
    CFG_SPARE_AVAIL = 3'd2,
    CFG_PPB         = 3'd3,
    CFG_CHIP_PAGES  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_MODIFY,
    ST_DIVIDE,
    ST_ERASE
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
    logic [BYTE_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              status;
    logic              bad_block;
  } out_item_t;

endpackage

// ===== hdl/nfe_ram.sv =====
`timescale 1ns / 1ps
module nfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/nfe_rem.sv =====
`timescale 1ns / 1ps
module nfe_rem #(
  parameter int DVD_W = 10,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] shf_r, shf_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W:0]   trial;

  // Restoring remainder: one dividend bit enters per cycle, most significant first.
  always_comb begin
    trial    = {rem_r, shf_r[DVD_W-1]};
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DVD_W);
      shf_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      shf_nxt = shf_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = DVS_W'(trial);
      end
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/nand_flash_array_emulator.sv =====
`timescale 1ns / 1ps
// Byte-wide NAND flash emulator backed by one synchronous byte memory.
// Issue an operation by raising start with in_data while busy is low; the
// transfer happens at that clock edge. Each operation gives exactly one
// result, shown on out_data for a single cycle with out_valid high. The
// receiver cannot hold a result off, so it must sample it in that cycle.
// Reads, programs and bad-block checks pass through the decode, access and
// modify states before the result is registered; mark bad ends in access,
// and rejected operations and checks with no room for a marker end in
// decode. Every access goes through the one byte memory, whose read data is
// registered, and the next operation is taken in the cycle the result appears.
// Erase first finds the block start with a bit-serial remainder (one cycle
// per page-number bit), then writes the erased value one byte per cycle over
// each page of the block, spare bytes included. After reset the block runs
// a fill pass over all MAX_PAGES pages that writes the initial image; busy is
// high during it. The cfg_ port writes a register at any edge with cfg_we
// high and should only be used while no operation is outstanding.
module nand_flash_array_emulator #(
  parameter int MAX_PAGE_BYTES  = nfe_pkg::DEF_MAX_PAGE_BYTES,
  parameter int MAX_SPARE_BYTES = nfe_pkg::DEF_MAX_SPARE_BYTES,
  parameter int MAX_PAGES       = nfe_pkg::DEF_MAX_PAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  nfe_pkg::in_item_t              in_data,
  output logic                           out_valid,
  output nfe_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [nfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  import nfe_pkg::*;

  localparam int STRIDE = MAX_PAGE_BYTES + MAX_SPARE_BYTES;
  localparam int DEPTH  = MAX_PAGES * STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OFF_W  = $clog2(STRIDE);
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int LAST_W = CHIP_PAGES_W + 1;

  state_t state_r, state_nxt;

  logic [PAGE_BYTES_W-1:0]  pb_r;
  logic [SPARE_BYTES_W-1:0] sb_r;
  logic [SPARE_AVAIL_W-1:0] sa_r;
  logic [PPB_W-1:0]         ppb_r;
  logic [CHIP_PAGES_W-1:0]  cp_r;

  in_item_t                 in_r;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [OFF_W-1:0]         off_r, off_nxt;
  logic [ADDR_W-1:0]        walk_addr_r, walk_addr_nxt;
  logic [OFF_W-1:0]         walk_off_r, walk_off_nxt;
  logic [CNT_W-1:0]         walk_pg_r, walk_pg_nxt;
  logic [CNT_W-1:0]         walk_last_r, walk_last_nxt;
  logic [CNT_W-1:0]         walk_pg_inc;
  logic                     walk_wrap;
  logic                     walk_end;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic [PAGE_BYTES_W-1:0]  used_pb;
  logic [SPARE_BYTES_W-1:0] used_sb;
  logic [SPARE_AVAIL_W-1:0] used_sa;
  logic [CHIP_PAGES_W-1:0]  used_cp;
  logic [PPB_W-1:0]         ppb_eff;
  logic                     page_ok;
  logic                     room;
  logic                     op_ok;
  logic                     check_direct;
  func_t                    fn;

  logic [PAGE_W-1:0]        mul_in;
  logic [ADDR_W-1:0]        mul_out;
  logic [ADDR_W-1:0]        acc_addr;
  logic [OFF_W-1:0]         off_sel;
  logic [PAGE_W-1:0]        first_pg;
  logic [LAST_W-1:0]        last_sum;
  logic [LAST_W-1:0]        last_sel;

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [BYTE_W-1:0]        mem_wdata;
  logic                     mem_re;
  logic [BYTE_W-1:0]        mem_rdata;

  logic                     div_start;
  logic                     div_done;
  logic [PPB_W-1:0]         div_rem;

  nfe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (acc_addr),
    .rdata (mem_rdata)
  );

  nfe_rem #(
    .DVD_W (PAGE_W),
    .DVS_W (PPB_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_r.page),
    .divisor  (ppb_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Registers beyond the store clamp to it; spare avail clamps to spare bytes.
  always_comb begin
    used_pb = pb_r;
    if (32'(pb_r) > 32'(MAX_PAGE_BYTES)) begin
      used_pb = PAGE_BYTES_W'(MAX_PAGE_BYTES);
    end
    used_sb = sb_r;
    if (32'(sb_r) > 32'(MAX_SPARE_BYTES)) begin
      used_sb = SPARE_BYTES_W'(MAX_SPARE_BYTES);
    end
    used_sa = (sa_r > used_sb) ? used_sb : sa_r;
    used_cp = cp_r;
    if (32'(cp_r) > 32'(MAX_PAGES)) begin
      used_cp = CHIP_PAGES_W'(MAX_PAGES);
    end
    ppb_eff = (ppb_r == '0) ? PPB_W'(1) : ppb_r;
  end

  assign fn      = func_t'(in_r.func);
  assign page_ok = CHIP_PAGES_W'(in_r.page) < used_cp;
  assign room    = used_sb > used_sa;

  always_comb begin
    op_ok   = 1'b0;
    off_sel = OFF_W'(in_r.column);
    unique case (fn) inside
      FN_READ_MAIN, FN_PROG_MAIN: begin
        op_ok = page_ok && (PAGE_BYTES_W'(in_r.column) < used_pb);
      end
      FN_READ_SPARE, FN_PROG_SPARE: begin
        op_ok   = page_ok && (in_r.column < COL_W'(used_sa));
        off_sel = OFF_W'(MAX_PAGE_BYTES) + OFF_W'(in_r.column);
      end
      FN_ERASE: begin
        op_ok = page_ok;
      end
      FN_MARK_BAD, FN_CHECK_BAD: begin
        // With no room for a marker, check bad succeeds and reports a good block.
        op_ok   = room ? page_ok : (fn == FN_CHECK_BAD);
        off_sel = OFF_W'(MAX_PAGE_BYTES) + OFF_W'(used_sb) - OFF_W'(1);
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign check_direct = (fn == FN_CHECK_BAD) && !room;

  // One constant multiplier serves the byte address and the erase start.
  assign first_pg = in_r.page - PAGE_W'(div_rem);
  assign mul_in   = (state_r == ST_DIVIDE) ? first_pg : in_r.page;
  assign mul_out  = ADDR_W'(mul_in) * ADDR_W'(STRIDE);
  assign acc_addr = base_r + ADDR_W'(off_r);
  assign last_sum = LAST_W'(first_pg) + LAST_W'(ppb_eff);
  assign last_sel = (last_sum < LAST_W'(used_cp)) ? last_sum : LAST_W'(used_cp);

  assign walk_pg_inc = walk_pg_r + CNT_W'(1);
  assign walk_wrap   = walk_off_r == OFF_W'(STRIDE - 1);
  assign walk_end    = walk_wrap && (walk_pg_inc == walk_last_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (walk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!op_ok || check_direct) begin
          state_nxt = ST_IDLE;
        end else if (fn == FN_ERASE) begin
          state_nxt = ST_DIVIDE;
        end else begin
          state_nxt = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        state_nxt = (fn == FN_MARK_BAD) ? ST_IDLE : ST_MODIFY;
      end
      ST_MODIFY: begin
        state_nxt = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_ERASE;
        end
      end
      ST_ERASE: begin
        if (walk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mem_we        = 1'b0;
    mem_waddr     = acc_addr;
    mem_wdata     = mem_rdata & in_r.write_data;
    mem_re        = 1'b0;
    div_start     = 1'b0;
    base_nxt      = base_r;
    off_nxt       = off_r;
    walk_addr_nxt = walk_addr_r;
    walk_off_nxt  = walk_off_r;
    walk_pg_nxt   = walk_pg_r;
    walk_last_nxt = walk_last_r;

    unique case (state_r) inside
      ST_CLEAR, ST_ERASE: begin
        mem_we    = 1'b1;
        mem_waddr = walk_addr_r;
        mem_wdata = BYTE_ERASED;
        if (state_r == ST_CLEAR &&
            walk_off_r < OFF_W'(MAX_PAGE_BYTES + INIT_SPARE_AVAIL)) begin
          mem_wdata = BYTE_FILL;
        end
        walk_addr_nxt = walk_addr_r + ADDR_W'(1);
        if (walk_wrap) begin
          walk_off_nxt = '0;
          walk_pg_nxt  = walk_pg_inc;
        end else begin
          walk_off_nxt = walk_off_r + OFF_W'(1);
        end
        if (state_r == ST_ERASE && walk_end) begin
          out_valid_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
      end
      ST_DECODE: begin
        base_nxt = mul_out;
        off_nxt  = off_sel;
        if (!op_ok) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = 1'b1;
        end else if (check_direct) begin
          out_valid_nxt = 1'b1;
        end else if (fn == FN_ERASE) begin
          div_start = 1'b1;
        end
      end
      ST_ACCESS: begin
        if (fn == FN_MARK_BAD) begin
          mem_we        = 1'b1;
          mem_wdata     = BYTE_ZERO;
          out_valid_nxt = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_MODIFY: begin
        out_valid_nxt = 1'b1;
        case (fn) inside
          FN_READ_MAIN, FN_READ_SPARE: begin
            out_nxt.read_data = mem_rdata;
          end
          FN_PROG_MAIN, FN_PROG_SPARE: begin
            mem_we = 1'b1;
          end
          FN_CHECK_BAD: begin
            out_nxt.bad_block = mem_rdata != BYTE_ERASED;
          end
          default: begin
          end
        endcase
      end
      ST_DIVIDE: begin
        if (div_done) begin
          walk_addr_nxt = mul_out;
          walk_off_nxt  = '0;
          walk_pg_nxt   = CNT_W'(first_pg);
          walk_last_nxt = CNT_W'(last_sel);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_addr_r <= '0;
      walk_off_r  <= '0;
      walk_pg_r   <= '0;
      walk_last_r <= CNT_W'(MAX_PAGES);
      out_valid_r <= 1'b0;
      pb_r        <= RST_PAGE_BYTES;
      sb_r        <= RST_SPARE_BYTES;
      sa_r        <= RST_SPARE_AVAIL;
      ppb_r       <= RST_PPB;
      cp_r        <= RST_CHIP_PAGES;
    end else begin
      state_r     <= state_nxt;
      walk_addr_r <= walk_addr_nxt;
      walk_off_r  <= walk_off_nxt;
      walk_pg_r   <= walk_pg_nxt;
      walk_last_r <= walk_last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_BYTES:  pb_r  <= cfg_data[PAGE_BYTES_W-1:0];
          CFG_SPARE_BYTES: sb_r  <= cfg_data[SPARE_BYTES_W-1:0];
          CFG_SPARE_AVAIL: sa_r  <= cfg_data[SPARE_AVAIL_W-1:0];
          CFG_PPB:         ppb_r <= cfg_data[PPB_W-1:0];
          CFG_CHIP_PAGES:  cp_r  <= cfg_data[CHIP_PAGES_W-1:0];
          default: begin
          end
        endcase
      end
    end
    if (state_r == ST_IDLE && start) begin
      in_r <= in_data;
    end
    base_r <= base_nxt;
    off_r  <= off_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
